// ===== rtl/gpgj_pkg.sv =====
// Package for the GF(2) partial Gauss-Jordan unit: command, status and
// register codes, widths and the control bundle sent to the row cells.
// No dependencies.
`default_nettype none
package gpgj_pkg;

  localparam int DEF_MAX_ROWS      = 64;
  localparam int DEF_WORDS_PER_ROW = 4;

  // widest row count (holds 1024) and widest column index (4096 columns)
  localparam int RCW   = 11;
  localparam int COL_W = 12;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_RUN   = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;  // unused code, ignored

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_GEOM = 2'd2;

  localparam logic [1:0] CFG_FIRST_ROW = 2'd0;
  localparam logic [1:0] CFG_FIRST_COL = 2'd1;
  localparam logic [1:0] CFG_PIVOTS    = 2'd2;
  localparam logic [1:0] CFG_ROW_WIDTH = 2'd3;

  // control broadcast to every cell
  typedef struct packed {
    logic             wr_en;
    logic [RCW-1:0]   wr_row;
    logic             xor_en;
    logic             pin_dst;   // xor regardless of the pivot bit
    logic [RCW-1:0]   lo;        // xor row range, lo inclusive
    logic [RCW-1:0]   hi;        // hi exclusive
    logic             tok_load;
    logic             tok_shift;
    logic [RCW-1:0]   tok_row;
    logic [COL_W-1:0] col;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/gpgj_cell.sv =====
// One matrix row cell: holds the row bits, its pivot bit and a token stage.
// Depends on gpgj_pkg.
`default_nettype none
module gpgj_cell #(
  parameter int WORDS_PER_ROW = gpgj_pkg::DEF_WORDS_PER_ROW,
  parameter int ROW_ID        = 0
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire gpgj_pkg::cell_ctrl_t          ctrl,
  input  wire logic [WORDS_PER_ROW*64-1:0]   wr_mask,
  input  wire logic [WORDS_PER_ROW*64-1:0]   wr_val,
  input  wire logic [WORDS_PER_ROW*64-1:0]   src_row,
  input  wire logic                          tok_in,
  output logic                               tok,
  output logic                               pbit,
  output logic [WORDS_PER_ROW*64-1:0]        row_bits
);
  import gpgj_pkg::*;

  localparam int TOT = WORDS_PER_ROW * 64;
  localparam int CIW = $clog2(TOT);
  localparam logic [CIW-1:0] TOP_BIT = CIW'(TOT - 1);
  localparam logic [RCW-1:0] MY_ROW  = RCW'(ROW_ID);

  logic [CIW-1:0] bit_idx;
  logic           in_range;
  logic           do_xor;

  // column c sits at bit TOT-1-c, word 0 at the top
  assign bit_idx  = TOP_BIT - ctrl.col[CIW-1:0];
  assign pbit     = row_bits[bit_idx];
  assign in_range = (MY_ROW >= ctrl.lo) && (MY_ROW < ctrl.hi);
  assign do_xor   = ctrl.xor_en && in_range && (ctrl.pin_dst || pbit);

  // row storage
  always_ff @(posedge clk) begin
    if (ctrl.wr_en && ctrl.wr_row == MY_ROW) begin
      row_bits <= (row_bits & ~wr_mask) | (wr_val & wr_mask);
    end else if (do_xor) begin
      row_bits <= row_bits ^ src_row;
    end
  end

  // token: marks the source row, walks down the chain during a pivot search
  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= 1'b0;
    end else if (ctrl.tok_load) begin
      tok <= (ctrl.tok_row == MY_ROW);
    end else if (ctrl.tok_shift) begin
      tok <= tok_in;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/gf2_partial_gauss_jordan_unit.sv =====
// GF(2) partial Gauss-Jordan unit: a chain of row cells plus a sequencer.
// Write beat: written at accept, no result. Read beat: result in the cycle
// after accept. Run beat: per window row a test step; a row lacking its pivot
// adds search steps as the token walks the cell chain and, when one is found,
// a fix step; a row with its pivot then gets a clear step. Then backward steps
// and a finish step. Input is stalled during a run.
// Reset clears control and config; row contents are undefined until written.
`default_nettype none
module gf2_partial_gauss_jordan_unit #(
  parameter int MAX_ROWS      = gpgj_pkg::DEF_MAX_ROWS,
  parameter int WORDS_PER_ROW = gpgj_pkg::DEF_WORDS_PER_ROW
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [5:0]  row_index,
  input  wire logic [1:0]  word_index,
  input  wire logic [63:0] word_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [63:0]      read_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_data
);
  import gpgj_pkg::*;

  localparam int TOT = WORDS_PER_ROW * 64;
  localparam int RIW = $clog2(MAX_ROWS);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FTEST = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_FIX   = 7'b0001000,
    S_ELIM  = 7'b0010000,
    S_BWD   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state;

  // configuration
  logic [5:0] first_row;
  logic [7:0] first_col;
  logic [6:0] pivots;
  logic [8:0] row_width;

  // run registers
  logic [RCW-1:0]   i_row;
  logic [RCW-1:0]   k_row;
  logic [RCW-1:0]   end_row;
  logic [COL_W-1:0] col;
  logic [TOT-1:0]   wmask;

  // cell chain signals
  cell_ctrl_t             ctrl;
  logic [MAX_ROWS-1:0]    tok_v;
  logic [MAX_ROWS-1:0]    pbits;
  logic [TOT-1:0]         rows [MAX_ROWS];
  logic [TOT-1:0]         src_bus;
  logic [TOT-1:0]         wr_mask;
  logic [TOT-1:0]         wr_val;

  logic           in_acc;
  logic           wfits;
  logic [RCW-1:0] row_ext;
  logic [RCW-1:0] first_ext;
  logic           geom_err;
  logic [9:0]     nw;
  logic [TOT-1:0] run_mask;
  logic [63:0]    rd_word;
  logic           pb_i;
  logic           hit;
  logic           last_i;
  logic           out_free;
  logic           out_load;

  assign in_stall  = (state != S_IDLE) || (out_valid && out_stall);
  assign in_acc    = in_valid && !in_stall;
  assign row_ext   = RCW'(row_index);
  assign first_ext = RCW'(first_row);
  assign wfits     = (32'(row_index) < 32'(MAX_ROWS)) &&
                     (32'(word_index) < 32'(WORDS_PER_ROW));
  assign geom_err  = (32'(first_row) + 32'(pivots) > 32'(MAX_ROWS)) ||
                     (32'(first_col) + 32'(pivots) > 32'(row_width)) ||
                     (32'(row_width) > 32'(TOT));
  assign nw        = (10'(row_width) + 10'd63) >> 6;
  assign pb_i      = pbits[i_row[RIW-1:0]];
  assign hit       = |(tok_v & pbits);
  assign last_i    = (i_row + RCW'(1)) == end_row;
  assign out_free  = !out_valid || !out_stall;

  // a result is loaded on a read, an immediate run answer or a finished run
  assign out_load  = (state == S_IDLE && in_acc &&
                      (cmd == CMD_READ ||
                       (cmd == CMD_RUN && (geom_err || pivots == 7'd0)))) ||
                     (state == S_DONE && out_free);

  // word masks for writes and for a run, word read select
  always_comb begin
    wr_mask  = '0;
    wr_val   = '0;
    run_mask = '0;
    rd_word  = '0;
    for (int q = 0; q < WORDS_PER_ROW; q++) begin
      wr_val[(WORDS_PER_ROW-1-q)*64 +: 64] = word_data;
      if (32'(word_index) == 32'(q)) begin
        wr_mask[(WORDS_PER_ROW-1-q)*64 +: 64] = '1;
        if (wfits) begin
          rd_word = rows[row_ext[RIW-1:0]][(WORDS_PER_ROW-1-q)*64 +: 64];
        end
      end
      if (32'(q) < 32'(nw)) begin
        run_mask[(WORDS_PER_ROW-1-q)*64 +: 64] = '1;
      end
    end
  end

  // source row: the row holding the token
  always_comb begin
    src_bus = '0;
    for (int r = 0; r < MAX_ROWS; r++) begin
      src_bus = src_bus | (rows[r] & {TOT{tok_v[r]}});
    end
    src_bus = src_bus & wmask;
  end

  // cell control
  always_comb begin
    ctrl        = '0;
    ctrl.col    = col;
    ctrl.wr_row = row_ext;
    if (in_acc && cmd == CMD_WRITE && wfits) begin
      ctrl.wr_en = 1'b1;
    end
    unique case (state)
      S_FTEST: begin
        ctrl.tok_load = 1'b1;
        ctrl.tok_row  = (pb_i || last_i) ? i_row : i_row + RCW'(1);
      end
      S_SCAN: begin
        if (!hit && (k_row + RCW'(1)) != end_row) begin
          ctrl.tok_shift = 1'b1;
        end else if (!hit && last_i) begin
          ctrl.tok_load = 1'b1;
          ctrl.tok_row  = i_row;
        end
      end
      S_FIX: begin
        ctrl.xor_en   = 1'b1;
        ctrl.pin_dst  = 1'b1;
        ctrl.lo       = i_row;
        ctrl.hi       = i_row + RCW'(1);
        ctrl.tok_load = 1'b1;
        ctrl.tok_row  = i_row;
      end
      S_ELIM: begin
        ctrl.xor_en = 1'b1;
        ctrl.lo     = i_row + RCW'(1);
        ctrl.hi     = end_row;
      end
      S_BWD: begin
        ctrl.xor_en = pb_i;
        ctrl.lo     = first_ext;
        ctrl.hi     = i_row;
        if (i_row != first_ext) begin
          ctrl.tok_load = 1'b1;
          ctrl.tok_row  = i_row - RCW'(1);
        end
      end
      S_IDLE, S_DONE: ;
      default: ;
    endcase
  end

  // row cells, token passed from each cell to the next
  for (genvar g = 0; g < MAX_ROWS; g++) begin : g_cell
    logic tin;
    if (g == 0) begin : g_head
      assign tin = 1'b0;
    end else begin : g_link
      assign tin = tok_v[g-1];
    end
    gpgj_cell #(
      .WORDS_PER_ROW(WORDS_PER_ROW),
      .ROW_ID       (g)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .wr_mask (wr_mask),
      .wr_val  (wr_val),
      .src_row (src_bus),
      .tok_in  (tin),
      .tok     (tok_v[g]),
      .pbit    (pbits[g]),
      .row_bits(rows[g])
    );
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_row <= '0;
      first_col <= '0;
      pivots    <= '0;
      row_width <= 9'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIRST_ROW: first_row <= cfg_data[5:0];
        CFG_FIRST_COL: first_col <= cfg_data[7:0];
        CFG_PIVOTS:    pivots    <= cfg_data[6:0];
        CFG_ROW_WIDTH: row_width <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && out_stall);
      unique case (state)
        S_IDLE: begin
          if (in_acc && cmd == CMD_READ) begin
            status    <= ST_READ;
            read_data <= rd_word;
          end else if (in_acc && cmd == CMD_RUN) begin
            if (geom_err || pivots == 7'd0) begin
              status    <= geom_err ? ST_GEOM : ST_DONE;
              read_data <= '0;
            end else begin
              i_row   <= first_ext;
              end_row <= first_ext + RCW'(pivots);
              col     <= COL_W'(first_col);
              wmask   <= run_mask;
              state   <= S_FTEST;
            end
          end
        end
        S_FTEST: begin
          if (pb_i) begin
            state <= S_ELIM;
          end else if (!last_i) begin
            k_row <= i_row + RCW'(1);
            state <= S_SCAN;
          end else begin
            state <= S_BWD;
          end
        end
        S_SCAN: begin
          if (hit) begin
            state <= S_FIX;
          end else if ((k_row + RCW'(1)) != end_row) begin
            k_row <= k_row + RCW'(1);
          end else if (last_i) begin
            state <= S_BWD;
          end else begin
            i_row <= i_row + RCW'(1);
            col   <= col + COL_W'(1);
            state <= S_FTEST;
          end
        end
        S_FIX: state <= S_ELIM;
        S_ELIM: begin
          if (last_i) begin
            state <= S_BWD;
          end else begin
            i_row <= i_row + RCW'(1);
            col   <= col + COL_W'(1);
            state <= S_FTEST;
          end
        end
        S_BWD: begin
          if (i_row == first_ext) begin
            state <= S_DONE;
          end else begin
            i_row <= i_row - RCW'(1);
            col   <= col - COL_W'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            status    <= ST_DONE;
            read_data <= '0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
